[rtl/srmva_pkg.sv]
// ---------------------------------------------------------------------------
// srmva_pkg - shared types and constants
// Item formats, kind codes and arithmetic widths for the sparse row
// matrix-vector accumulate block.
// ---------------------------------------------------------------------------
package srmva_pkg;

    // Store and arithmetic sizing
    localparam int X_DEPTH   = 1024;
    localparam int X_ADDR_W  = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int FRAC_BITS = 16;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int IDX_EXT_W = X_ADDR_W + IDX_W;

    // Saturation limits, held at product width
    localparam logic signed [PROD_W-1:0] ACC_MAX = (PROD_W'(1) <<< (ACC_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ACC_MIN = -ACC_MAX - PROD_W'(1);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_XWRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    last_in_row;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] row_sum;
        logic                    saturated;
    } t_out_item;

    // Product stage handed from the fetch/multiply side to the accumulator
    typedef struct packed {
        logic                     valid;
        logic                     start;
        logic                     last;
        logic signed [PROD_W-1:0] data;
    } t_prod_stage;

endpackage

[rtl/sparse_row_matrix_vector_accumulate.sv]
// A row-ending item's result passes the x store read and stage 1 registers, the stage 2
// product register and the output register; a row end meeting a full result register stalls.
// Throughput: one item per clock unless stalled; the x store read and the single 32x32 multiply are pipelined.
// Reset: control and accumulator clear; x store contents are undefined until written.
// ---------------------------------------------------------------------------
// sparse_row_matrix_vector_accumulate - row-wise sparse y = A*x + y
// Fixed-point CSR matrix-vector accumulate with an on-chip x store and a
// saturating 48-bit row accumulator.
// ---------------------------------------------------------------------------
module sparse_row_matrix_vector_accumulate (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  srmva_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output srmva_pkg::t_out_item o_out_item
);

    logic                   w_stall;
    logic                   w_accept;
    srmva_pkg::t_prod_stage w_stage;

    // Input transfer whenever the pipe moves
    assign o_in_ready = !w_stall;
    assign w_accept   = i_in_valid && !w_stall;

    srmva_fetch u_fetch (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_advance (!w_stall),
        .i_item    (i_in_item),
        .o_stage   (w_stage)
    );

    srmva_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .i_out_ready (i_out_ready),
        .o_stall     (w_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/srmva_ram.sv]
// ---------------------------------------------------------------------------
// srmva_ram - generic single-clock RAM
// One write port and one read port; read data registered, held when the
// read enable is low.
// ---------------------------------------------------------------------------
module srmva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/srmva_fetch.sv]
// ---------------------------------------------------------------------------
// srmva_fetch - x store access and multiply
// Writes x entries, reads x[column] for nonzeros, and forms the exact
// signed product from the registered read; start items carry their value.
// ---------------------------------------------------------------------------
module srmva_fetch (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_advance,
    input  srmva_pkg::t_in_item    i_item,
    output srmva_pkg::t_prod_stage o_stage
);

    logic [srmva_pkg::IDX_EXT_W-1:0]  w_idx_ext;
    logic [srmva_pkg::X_ADDR_W-1:0]   w_addr;
    logic                             w_in_range;
    logic                             w_we;
    logic                             w_re;
    logic                             w_keep;
    logic [srmva_pkg::VAL_W-1:0]      w_rdata;
    logic signed [srmva_pkg::VAL_W-1:0]  w_x;
    logic signed [srmva_pkg::PROD_W-1:0] w_prod;

    // Stage 1 registers
    logic                             r_s1_valid;
    logic                             r_s1_start;
    logic                             r_s1_last;
    logic                             r_s1_in_range;
    logic signed [srmva_pkg::VAL_W-1:0] r_s1_value;

    // Stage 2 registers
    srmva_pkg::t_prod_stage           r_s2;
    srmva_pkg::t_prod_stage           n_s2;

    // Address and range check
    assign w_idx_ext  = srmva_pkg::IDX_EXT_W'(i_item.index);
    assign w_addr     = w_idx_ext[srmva_pkg::X_ADDR_W-1:0];
    assign w_in_range = (w_idx_ext < srmva_pkg::IDX_EXT_W'(srmva_pkg::X_DEPTH));

    // Kind decode
    always_comb begin
        w_we   = 1'b0;
        w_re   = 1'b0;
        w_keep = 1'b0;
        case (i_item.kind)
            srmva_pkg::KIND_XWRITE: begin
                w_we = i_accept && w_in_range;
            end
            srmva_pkg::KIND_START: begin
                w_keep = i_accept;
            end
            srmva_pkg::KIND_NONZERO: begin
                w_re   = i_accept;
                w_keep = i_accept;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    srmva_ram #(
        .WIDTH (srmva_pkg::VAL_W),
        .DEPTH (srmva_pkg::X_DEPTH)
    ) u_x_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (i_item.value),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Stage 1: item beside the pending x read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid <= w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_start    <= (i_item.kind == srmva_pkg::KIND_START);
            r_s1_last     <= i_item.last_in_row;
            r_s1_in_range <= w_in_range;
            r_s1_value    <= i_item.value;
        end
    end

    // Multiply; out-of-range columns read x as zero
    assign w_x    = r_s1_in_range ? $signed(w_rdata) : '0;
    assign w_prod = r_s1_value * w_x;

    always_comb begin
        n_s2.valid = r_s1_valid;
        n_s2.start = r_s1_start;
        n_s2.last  = r_s1_last;
        n_s2.data  = r_s1_start ? srmva_pkg::PROD_W'(r_s1_value) : w_prod;
    end

    // Stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_advance) begin
            r_s2.valid <= n_s2.valid;
        end
        if (i_advance) begin
            r_s2.start <= n_s2.start;
            r_s2.last  <= n_s2.last;
            r_s2.data  <= n_s2.data;
        end
    end

    assign o_stage = r_s2;

endmodule

[rtl/srmva_accum.sv]
// ---------------------------------------------------------------------------
// srmva_accum - saturating row accumulator and result register
// Floors each product to the fixed-point grid, adds it with 48-bit
// saturation, and holds finished row sums for the output transfer.
// ---------------------------------------------------------------------------
module srmva_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  srmva_pkg::t_prod_stage i_stage,
    input  logic                   i_out_ready,
    output logic                   o_stall,
    output logic                   o_out_valid,
    output srmva_pkg::t_out_item   o_out_item
);

    logic signed [srmva_pkg::ACC_W-1:0]  r_acc;
    logic signed [srmva_pkg::ACC_W-1:0]  n_acc;
    logic                                r_sat;
    logic                                n_sat;
    logic                                r_out_valid;
    logic                                n_out_valid;
    srmva_pkg::t_out_item                r_out_item;

    logic                                w_fire;
    logic                                w_emit;
    logic signed [srmva_pkg::PROD_W-1:0] w_shift;
    logic signed [srmva_pkg::PROD_W-1:0] w_sum;
    logic signed [srmva_pkg::ACC_W-1:0]  w_val;
    logic                                w_flag;

    // Hold the pipe when a row end meets a full, undrained result register
    assign o_stall = i_stage.valid && i_stage.last && r_out_valid && !i_out_ready;
    assign w_fire  = i_stage.valid && !o_stall;
    assign w_emit  = w_fire && i_stage.last;

    // Floor shift and wide add
    assign w_shift = i_stage.data >>> srmva_pkg::FRAC_BITS;
    assign w_sum   = srmva_pkg::PROD_W'(r_acc) + w_shift;

    // Start load or saturating accumulate
    always_comb begin
        if (i_stage.start) begin
            w_val  = i_stage.data[srmva_pkg::ACC_W-1:0];
            w_flag = 1'b0;
        end else if (w_sum > srmva_pkg::ACC_MAX) begin
            w_val  = srmva_pkg::ACC_MAX[srmva_pkg::ACC_W-1:0];
            w_flag = 1'b1;
        end else if (w_sum < srmva_pkg::ACC_MIN) begin
            w_val  = srmva_pkg::ACC_MIN[srmva_pkg::ACC_W-1:0];
            w_flag = 1'b1;
        end else begin
            w_val  = w_sum[srmva_pkg::ACC_W-1:0];
            w_flag = r_sat;
        end
    end

    // Accumulator update; clears after a row result
    always_comb begin
        n_acc = r_acc;
        n_sat = r_sat;
        if (w_fire) begin
            if (i_stage.last) begin
                n_acc = '0;
                n_sat = 1'b0;
            end else begin
                n_acc = w_val;
                n_sat = w_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_sat <= n_sat;
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item.row_sum   <= w_val;
            r_out_item.saturated <= w_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
